@@ hdl/pist_pkg.sv @@
// shared types and constants for the partial insertion sort top-k selector
// used by pist_cell, pist_ctrl and partial_insertion_sort_topk; no dependencies
package pist_pkg;

    // width and reset value of the top count register
    localparam int TOP_BITS        = 5;
    localparam int TOP_COUNT_RESET = 10;

    // width of the rank field in each result item
    localparam int RANK_BITS = 4;

    // controller states
    typedef enum logic [0:0] {
        ST_COLLECT,
        ST_DRAIN
    } t_state;

    // commands broadcast to every cell of the chain
    typedef struct packed {
        logic insert;
        logic shift;
    } t_chain_ctl;

    // status of the head of the chain, seen by the controller
    typedef struct packed {
        logic head_valid;
        logic head_last;
    } t_chain_status;

endpackage

@@ hdl/pist_cell.sv @@
// one cell of the insertion chain: holds a key, a record id and a valid bit
// depends on pist_pkg for the chain command struct
module pist_cell #(
    parameter int KEY_BITS = 16,
    parameter int ID_BITS  = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pist_pkg::t_chain_ctl  i_ctl,
    input  logic                  i_en,
    input  logic [KEY_BITS-1:0]   i_key,
    input  logic [ID_BITS-1:0]    i_id,
    input  logic [KEY_BITS-1:0]   i_prev_key,
    input  logic [ID_BITS-1:0]    i_prev_id,
    input  logic                  i_prev_veff,
    input  logic                  i_prev_gt,
    input  logic [KEY_BITS-1:0]   i_next_key,
    input  logic [ID_BITS-1:0]    i_next_id,
    input  logic                  i_next_valid,
    output logic [KEY_BITS-1:0]   o_key,
    output logic [ID_BITS-1:0]    o_id,
    output logic                  o_valid,
    output logic                  o_veff,
    output logic                  o_gt
);
    import pist_pkg::*;

    logic [KEY_BITS-1:0] r_key, n_key;
    logic [ID_BITS-1:0]  r_id, n_id;
    logic                r_valid, n_valid;
    logic                veff;
    logic                gt;

    // entry counts only while this cell lies below the top count
    assign veff = r_valid & i_en;
    // new key belongs here or above: slot empty or new key strictly smaller
    assign gt   = ~veff | (i_key < r_key);

    // next cell content: insert shifts down, drain shifts up
    always_comb begin
        n_key   = r_key;
        n_id    = r_id;
        n_valid = r_valid;
        if (i_ctl.shift) begin
            n_key   = i_next_key;
            n_id    = i_next_id;
            n_valid = i_next_valid;
        end else if (i_ctl.insert) begin
            if (i_prev_gt) begin
                n_key   = i_prev_key;
                n_id    = i_prev_id;
                n_valid = i_prev_veff;
            end else if (gt) begin
                n_key   = i_key;
                n_id    = i_id;
                n_valid = 1'b1;
            end else begin
                n_valid = veff;
            end
            if (!i_en) begin
                n_valid = 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_id  <= n_id;
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_key   = r_key;
    assign o_id    = r_id;
    assign o_valid = r_valid;
    assign o_veff  = veff;
    assign o_gt    = gt;

endmodule

@@ hdl/pist_ctrl.sv @@
// controller of the top-k selector: collect and drain phases, rank counter
// depends on pist_pkg for the state type and the chain structs
module pist_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_s_tvalid,
    input  logic                     i_s_tlast,
    input  logic                     i_m_tready,
    input  pist_pkg::t_chain_status  i_status,
    output logic                     o_s_tready,
    output logic                     o_m_tvalid,
    output logic                     o_m_tlast,
    output logic [pist_pkg::RANK_BITS-1:0] o_rank,
    output pist_pkg::t_chain_ctl     o_ctl
);
    import pist_pkg::*;

    t_state               r_state, n_state;
    logic [RANK_BITS-1:0] r_rank, n_rank;
    logic                 s_fire;
    logic                 m_fire;

    assign s_fire = i_s_tvalid & o_s_tready;
    assign m_fire = o_m_tvalid & i_m_tready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_COLLECT: begin
                if (s_fire && i_s_tlast) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (m_fire && i_status.head_last) begin
                    n_state = ST_COLLECT;
                end
            end
            default: n_state = ST_COLLECT;
        endcase
    end

    // outputs
    always_comb begin
        o_s_tready   = 1'b0;
        o_m_tvalid   = 1'b0;
        unique case (r_state)
            ST_COLLECT: o_s_tready = 1'b1;
            ST_DRAIN:   o_m_tvalid = i_status.head_valid;
            default:    o_s_tready = 1'b0;
        endcase
        o_m_tlast    = i_status.head_last;
        o_ctl.insert = s_fire;
        o_ctl.shift  = m_fire;
    end

    // rank counter, cleared after the final result of a set, else wraps at the rank field width
    always_comb begin
        n_rank = r_rank;
        if (m_fire) begin
            n_rank = i_status.head_last ? '0 : r_rank + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_COLLECT;
            r_rank  <= '0;
        end else begin
            r_state <= n_state;
            r_rank  <= n_rank;
        end
    end

    assign o_rank = r_rank;

endmodule

@@ hdl/partial_insertion_sort_topk.sv @@
// top level of the top-k selector: chain of insertion cells plus controller
// depends on pist_pkg, pist_cell and pist_ctrl
//
// Usage:
//   slave stream (i_s_*) carries records: key and record id in tdata,
//   tlast marks the final record of a set. Master stream (o_m_*) carries
//   results: rank, key and id in tdata, tlast on the final entry of a set.
//   The cfg channel writes top_count (1..MAX_KEPT kept, 0 acts as 1,
//   larger values saturate); always ready; the user must write it while idle, unchecked.
// Throughput: one record per cycle while collecting; every cell compares
//   the broadcast key in the same cycle and hands its entry to its neighbor.
// Drain: the record marked last is inserted in its accept cycle; the
//   first result is offered on the next cycle and one result per cycle
//   follows while the receiver is ready, read from the head cell as the
//   chain shifts toward it. Input is not accepted during the drain.
// Stall: while tready is low the head entry and rank hold.
// Reset: all cells empty, top_count back to 10, input ready.
module partial_insertion_sort_topk #(
    parameter int MAX_KEPT = 16,
    parameter int KEY_BITS = 16,
    parameter int ID_BITS  = 10
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // records
    input  logic i_s_tvalid,
    output logic o_s_tready,
    // fields from bit 0: sort_key, record_id, zero fill
    input  logic [((KEY_BITS+ID_BITS+7)/8)*8-1:0] i_s_tdata,
    // last_item
    input  logic i_s_tlast,
    // results
    output logic o_m_tvalid,
    input  logic i_m_tready,
    // fields from bit 0: rank, out_key, out_id, zero fill
    output logic [((pist_pkg::RANK_BITS+KEY_BITS+ID_BITS+7)/8)*8-1:0] o_m_tdata,
    // last_result
    output logic o_m_tlast,
    // top_count write channel
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  logic [pist_pkg::TOP_BITS-1:0] i_cfg_data
);
    import pist_pkg::*;

    logic [TOP_BITS-1:0]  r_top;
    logic [KEY_BITS-1:0]  in_key;
    logic [ID_BITS-1:0]   in_id;
    t_chain_ctl           ctl;
    t_chain_status        status;
    logic [RANK_BITS-1:0] rank;

    logic [KEY_BITS-1:0]  cell_key [MAX_KEPT+1];
    logic [ID_BITS-1:0]   cell_id  [MAX_KEPT+1];
    logic [MAX_KEPT:0]    cell_valid;
    logic [MAX_KEPT-1:0]  cell_veff;
    logic [MAX_KEPT-1:0]  cell_gt;
    logic [MAX_KEPT-1:0]  cell_en;

    // unpack the record
    assign in_key = i_s_tdata[KEY_BITS-1:0];
    assign in_id  = i_s_tdata[KEY_BITS +: ID_BITS];

    // top count register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top <= TOP_BITS'(TOP_COUNT_RESET);
        end else if (i_cfg_valid) begin
            r_top <= i_cfg_data;
        end
    end

    // empty slot past the tail of the chain
    assign cell_key[MAX_KEPT]   = '0;
    assign cell_id[MAX_KEPT]    = '0;
    assign cell_valid[MAX_KEPT] = 1'b0;

    // the insertion chain
    for (genvar g = 0; g < MAX_KEPT; g++) begin : g_cell
        logic [KEY_BITS-1:0] prev_key;
        logic [ID_BITS-1:0]  prev_id;
        logic                prev_veff;
        logic                prev_gt;

        // cell zero is always in use, the others only below the top count
        assign cell_en[g] = (g == 0) || (g < int'(r_top));

        if (g == 0) begin : g_head
            assign prev_key  = '0;
            assign prev_id   = '0;
            assign prev_veff = 1'b0;
            assign prev_gt   = 1'b0;
        end else begin : g_body
            assign prev_key  = cell_key[g-1];
            assign prev_id   = cell_id[g-1];
            assign prev_veff = cell_veff[g-1];
            assign prev_gt   = cell_gt[g-1];
        end

        pist_cell #(
            .KEY_BITS (KEY_BITS),
            .ID_BITS  (ID_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (ctl),
            .i_en         (cell_en[g]),
            .i_key        (in_key),
            .i_id         (in_id),
            .i_prev_key   (prev_key),
            .i_prev_id    (prev_id),
            .i_prev_veff  (prev_veff),
            .i_prev_gt    (prev_gt),
            .i_next_key   (cell_key[g+1]),
            .i_next_id    (cell_id[g+1]),
            .i_next_valid (cell_valid[g+1]),
            .o_key        (cell_key[g]),
            .o_id         (cell_id[g]),
            .o_valid      (cell_valid[g]),
            .o_veff       (cell_veff[g]),
            .o_gt         (cell_gt[g])
        );
    end

    // head status for the controller
    assign status.head_valid = cell_valid[0];
    assign status.head_last  = ~cell_valid[1];

    pist_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tlast  (i_s_tlast),
        .i_m_tready (i_m_tready),
        .i_status   (status),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tlast  (o_m_tlast),
        .o_rank     (rank),
        .o_ctl      (ctl)
    );

    // pack the result from the head cell
    always_comb begin
        o_m_tdata = '0;
        o_m_tdata[RANK_BITS-1:0]               = rank;
        o_m_tdata[RANK_BITS +: KEY_BITS]       = cell_key[0];
        o_m_tdata[RANK_BITS+KEY_BITS +: ID_BITS] = cell_id[0];
    end

`ifndef ASSERT_OFF
    // occupied cells always form an unbroken run from the head
    a_valid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((cell_valid >> 1) & ~cell_valid) == '0)
        else $error("gap in occupied cells");

    // input and output never handshake-enabled together
    a_phase_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid))
        else $error("collect and drain overlap");

    // a record marked last always leaves something to emit
    a_drain_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tlast) |=> o_m_tvalid)
        else $error("no result after last record");

    // the final result of a set empties the chain
    a_drain_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && o_m_tlast) |=> (o_s_tready && cell_valid == '0))
        else $error("chain not empty after final result");

    // kept keys stay in ascending order
    for (genvar a = 0; a + 1 < MAX_KEPT; a++) begin : g_order_chk
        a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            cell_valid[a+1] |-> (cell_key[a] <= cell_key[a+1]))
            else $error("kept keys out of order");
    end
`endif

endmodule
